@@ rtl/core/mhtir_pkg.sv @@
// Package for the modulo hash table insert/remove unit.
// Holds field widths, status codes, FSM state type and controller/datapath structs.
// No dependencies.
package mhtir_pkg;

   // Default geometry of the table
   localparam int BUCKETS_DEFAULT = 16;
   localparam int WAYS_DEFAULT    = 4;

   // Request and response field widths
   localparam int KEY_W    = 31;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;

   // Request kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED = 3'd0,
      STATUS_UPDATED  = 3'd1,
      STATUS_REMOVED  = 3'd2,
      STATUS_NOTFOUND = 3'd3,
      STATUS_FULL     = 3'd4
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_REM,
      S_EVAL
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic clr_wr;    // write a zero row during the clearing pass
      logic load;      // capture a request and restart the remainder unit
      logic rem_step;  // advance the remainder unit
      logic rd_en;     // read the bucket row
      logic commit;    // write the row back, update count, load response
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic clr_last;  // last row of the clearing pass
      logic rem_done;  // bucket index is ready
      logic out_free;  // response register can take a new result
   } dp_stat_type;

endpackage

@@ rtl/core/mhtir_if.sv @@
// Request and response channel interfaces for the hash table unit.
// Valid/ready handshake; payload widths from mhtir_pkg.
interface mhtir_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [mhtir_pkg::KEY_W-1:0]   key;
   logic [mhtir_pkg::VALUE_W-1:0] value;

   modport source (output valid, kind, key, value, input ready);
   modport sink   (input valid, kind, key, value, output ready);
endinterface

interface mhtir_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mhtir_pkg::STATUS_W-1:0] status;
   logic                           table_empty;

   modport source (output valid, status, table_empty, input ready);
   modport sink   (input valid, status, table_empty, output ready);
endinterface

@@ rtl/core/mhtir_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mhtir_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mhtir_ctrl.sv @@
// Controller FSM of the hash table unit: clearing pass, request intake,
// bucket lookup and row write-back sequencing. Uses mhtir_pkg.
module mhtir_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mhtir_pkg::dp_stat_type stat,
   output mhtir_pkg::dp_cmd_type  cmd
);

   mhtir_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mhtir_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mhtir_pkg::S_CLEAR: begin
            if (stat.clr_last) state_in = mhtir_pkg::S_IDLE;
         end
         mhtir_pkg::S_IDLE: begin
            if (req_valid) state_in = mhtir_pkg::S_REM;
         end
         mhtir_pkg::S_REM: begin
            if (stat.rem_done) state_in = mhtir_pkg::S_EVAL;
         end
         mhtir_pkg::S_EVAL: begin
            if (stat.out_free) state_in = mhtir_pkg::S_IDLE;
         end
         default: state_in = mhtir_pkg::S_CLEAR;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         mhtir_pkg::S_CLEAR: begin
            cmd.clr_wr = 1'b1;
         end
         mhtir_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         mhtir_pkg::S_REM: begin
            cmd.rem_step = 1'b1;
            cmd.rd_en    = stat.rem_done;
         end
         mhtir_pkg::S_EVAL: begin
            cmd.commit = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/core/mhtir_dp.sv @@
// Datapath of the hash table unit: request registers, bucket remainder unit,
// row RAM, way compare and update, entry count, response register.
// Uses mhtir_pkg and mhtir_ram.
module mhtir_dp #(
   parameter int BUCKETS = mhtir_pkg::BUCKETS_DEFAULT,
   parameter int WAYS    = mhtir_pkg::WAYS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_kind,
   input  logic [mhtir_pkg::KEY_W-1:0]     req_key,
   input  logic [mhtir_pkg::VALUE_W-1:0]   req_value,
   input  mhtir_pkg::dp_cmd_type           cmd,
   output mhtir_pkg::dp_stat_type          stat,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mhtir_pkg::STATUS_W-1:0]  rsp_status,
   output logic                            rsp_table_empty
);

   localparam int KW     = mhtir_pkg::KEY_W;
   localparam int VW     = mhtir_pkg::VALUE_W;
   localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int ROW_W  = WAYS * (KW + VW + 1);
   localparam int KEY_LO = WAYS * VW;
   localparam int VLD_LO = WAYS * (VW + KW);
   localparam int CNT_MAX = BUCKETS * WAYS;
   localparam int CNT_W  = $clog2(CNT_MAX + 1);
   localparam bit POW2   = ((BUCKETS & (BUCKETS - 1)) == 0);

   // Captured request
   logic          kind_ff;
   logic [KW-1:0] key_ff;
   logic [VW-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
   end

   // Bucket index = key mod BUCKETS
   logic [BW-1:0] bucket;

   if (BUCKETS == 1) begin : g_one
      assign bucket        = '0;
      assign stat.rem_done = 1'b1;
   end else if (POW2) begin : g_mask
      assign bucket        = key_ff[BW-1:0];
      assign stat.rem_done = 1'b1;
   end else begin : g_rem
      // Reciprocal multiply: q = (key * MREC) >> RSH is exact for any 31-bit key,
      // then bucket = key - q * BUCKETS, kept to the low BW bits
      localparam int            RSH      = KW + BW;
      localparam logic [KW:0]   MREC     = (KW + 1)'(((64'd1 << RSH) + 64'(BUCKETS) - 64'd1)
                                                     / 64'(BUCKETS));
      localparam logic [BW-1:0] BMOD     = BW'(BUCKETS);
      localparam logic [1:0]    REM_LAST = 2'd2;
      logic [2*KW:0]   prod_ff, prod_in;
      logic [BW-1:0]   r_ff, r_in;
      logic [1:0]      stp_ff, stp_in;
      logic [2*BW-1:0] qd;

      assign stat.rem_done = (stp_ff == REM_LAST);

      // Step 0 multiplies, step 1 corrects, then the index is ready
      always_comb begin
         prod_in = prod_ff;
         r_in    = r_ff;
         stp_in  = stp_ff;
         qd      = (2*BW)'(prod_ff[RSH +: BW]) * (2*BW)'(BMOD);
         if (cmd.load) begin
            stp_in = '0;
         end else if (cmd.rem_step && !stat.rem_done) begin
            if (stp_ff == 2'd0) begin
               prod_in = {{(KW + 1){1'b0}}, key_ff} * {{KW{1'b0}}, MREC};
            end else begin
               r_in = key_ff[BW-1:0] - qd[BW-1:0];
            end
            stp_in = stp_ff + 2'd1;
         end
      end

      always_ff @(posedge clock) begin
         prod_ff <= prod_in;
         r_ff    <= r_in;
         if (reset) begin
            stp_ff <= '0;
         end else begin
            stp_ff <= stp_in;
         end
      end

      assign bucket = r_ff;
   end

   // Clearing pass row counter
   logic [BW-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + BW'(1);
      end
   end

   assign stat.clr_last = (clr_ff == BW'(BUCKETS - 1));

   // Row memory: {valid[WAYS], keys[WAYS], values[WAYS]}
   logic             ram_wr_en;
   logic [BW-1:0]    ram_wr_addr;
   logic [ROW_W-1:0] ram_wr_data;
   logic [ROW_W-1:0] rd_row;
   logic [ROW_W-1:0] new_row;

   assign ram_wr_en   = cmd.clr_wr | cmd.commit;
   assign ram_wr_addr = cmd.clr_wr ? clr_ff : bucket;
   assign ram_wr_data = cmd.clr_wr ? '0 : new_row;

   mhtir_ram #(
      .WIDTH (ROW_W),
      .DEPTH (BUCKETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (bucket),
      .rd_data (rd_row)
   );

   // Way compare: lowest matching way and lowest free way
   logic [WAYS-1:0] vld;
   logic [WAYS-1:0] hit_sel;
   logic [WAYS-1:0] free_sel;
   logic            found;
   logic            has_free;

   assign vld = rd_row[VLD_LO +: WAYS];

   always_comb begin
      hit_sel  = '0;
      free_sel = '0;
      found    = 1'b0;
      has_free = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && vld[w] && (rd_row[KEY_LO + w*KW +: KW] == key_ff)) begin
            hit_sel[w] = 1'b1;
            found      = 1'b1;
         end
         if (!has_free && !vld[w]) begin
            free_sel[w] = 1'b1;
            has_free    = 1'b1;
         end
      end
   end

   // Row update, status and next count
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   mhtir_pkg::status_type status;

   always_comb begin
      new_row = rd_row;
      cnt_in  = cnt_ff;
      status  = mhtir_pkg::STATUS_NOTFOUND;
      if (kind_ff == mhtir_pkg::KIND_INSERT) begin
         if (found) begin
            for (int w = 0; w < WAYS; w++) begin
               if (hit_sel[w]) new_row[w*VW +: VW] = value_ff;
            end
            status = mhtir_pkg::STATUS_UPDATED;
         end else if (has_free) begin
            for (int w = 0; w < WAYS; w++) begin
               if (free_sel[w]) begin
                  new_row[w*VW +: VW]          = value_ff;
                  new_row[KEY_LO + w*KW +: KW] = key_ff;
                  new_row[VLD_LO + w]          = 1'b1;
               end
            end
            cnt_in = cnt_ff + CNT_W'(1);
            status = mhtir_pkg::STATUS_INSERTED;
         end else begin
            status = mhtir_pkg::STATUS_FULL;
         end
      end else begin
         if (found) begin
            for (int w = 0; w < WAYS; w++) begin
               if (hit_sel[w]) new_row[VLD_LO + w] = 1'b0;
            end
            if (cnt_ff != '0) cnt_in = cnt_ff - CNT_W'(1);
            status = mhtir_pkg::STATUS_REMOVED;
         end
      end
   end

   // Entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.commit) begin
         cnt_ff <= cnt_in;
      end
   end

   // Response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mhtir_pkg::STATUS_W-1:0] status_ff;
   logic                          empty_ff;

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in  = cmd.commit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.commit) begin
         status_ff <= status;
         empty_ff  <= (cnt_in == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_table_empty = empty_ff;

   // Checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CNT_MAX))
      else $error("entry count above table capacity");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> stat.out_free)
      else $error("result written over a pending response");

   a_insert_cnt: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && status == mhtir_pkg::STATUS_INSERTED)
      |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("insert did not bump the entry count");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (empty_ff == (cnt_ff == '0)))
      else $error("table_empty disagrees with entry count");

endmodule

@@ rtl/core/modulo_hash_table_insert_remove_unit.sv @@
// Top level of the modulo hash table insert/remove unit.
// Depends on mhtir_pkg, mhtir_if, mhtir_ram, mhtir_ctrl and mhtir_dp.
//
// Usage:
//   req_chan carries one request: kind (0 insert/update, 1 remove), a 31-bit
//   key and a 32-bit value handle. Each request gives exactly one response on
//   rsp_chan: a 3-bit status and table_empty. A key lives in bucket
//   key mod BUCKETS, each bucket holding WAYS entries.
//   After a request is accepted, the bucket row is read and then written back
//   as the response register is loaded. When BUCKETS is a power of two the
//   bucket is the low key bits; otherwise a reciprocal multiply and a
//   correction step come before the row read. A new request is taken in the
//   cycle after the response register is loaded.
//   Each request does one read and one write of a bucket row in the row RAM.
//   After reset the unit clears all valid marks in a pass over all BUCKETS rows,
//   one row per cycle, with req_chan.ready low; the entry count starts at zero.
//   When the receiver stalls, the finished response waits in the output
//   register while the next request is accepted and looked up; that request
//   holds in its write-back step until the output register frees up.
module modulo_hash_table_insert_remove_unit #(
   parameter int BUCKETS = mhtir_pkg::BUCKETS_DEFAULT,
   parameter int WAYS    = mhtir_pkg::WAYS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   mhtir_req_if.sink   req_chan,
   mhtir_rsp_if.source rsp_chan
);

   mhtir_pkg::dp_cmd_type  cmd;
   mhtir_pkg::dp_stat_type stat;

   mhtir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mhtir_dp #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_kind        (req_chan.kind),
      .req_key         (req_chan.key),
      .req_value       (req_chan.value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_status      (rsp_chan.status),
      .rsp_table_empty (rsp_chan.table_empty)
   );

endmodule

@@ dv/tb_top.sv @@
// Self-checking bench for modulo_hash_table_insert_remove_unit.
// Keeps its own copy of the bucket/way table to predict every response.
// Depends on mhtir_pkg, mhtir_if and the RTL of the unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BUCKETS  = mhtir_pkg::BUCKETS_DEFAULT;
   localparam int NUM_WAYS     = mhtir_pkg::WAYS_DEFAULT;
   localparam int NUM_SLOTS    = NUM_BUCKETS * NUM_WAYS;
   localparam int KEY_W        = mhtir_pkg::KEY_W;
   localparam int VALUE_W      = mhtir_pkg::VALUE_W;
   localparam int CLK_PERIOD   = 20;
   localparam int RESET_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
   localparam int TAIL_CYCLES  = 44;    // well past the slowest request period

   // Receiver stall patterns
   localparam int RSP_ALWAYS_READY = 0;
   localparam int RSP_RANDOM_HALF  = 1;
   localparam int RSP_EVERY_THIRD  = 2;
   localparam int RSP_SPARSE       = 3;

   typedef struct packed {
      mhtir_pkg::status_type status;
      logic                  table_empty;
   } table_result_type;

   logic clock;
   logic reset;

   mhtir_req_if req_chan ();
   mhtir_rsp_if rsp_chan ();

   modulo_hash_table_insert_remove_unit #(
      .BUCKETS (NUM_BUCKETS),
      .WAYS    (NUM_WAYS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow table
   logic               slot_valid [NUM_SLOTS];
   logic [KEY_W-1:0]   slot_key   [NUM_SLOTS];
   logic [VALUE_W-1:0] slot_value [NUM_SLOTS];
   int                 slot_count;

   table_result_type pending_results[$];
   int               mismatch_count;
   int               requests_sent;
   int               status_seen [5];
   int               empty_seen;
   bit               hold_rsp;

   // Clock
   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   // Apply one request to the shadow table and return the response it causes
   function automatic table_result_type apply_table_op(input logic kind,
                                                       input logic [KEY_W-1:0] key,
                                                       input logic [VALUE_W-1:0] value);
      table_result_type res;
      int base;
      int hit;
      int spare;
      base  = int'(key % NUM_BUCKETS) * NUM_WAYS;
      hit   = -1;
      spare = -1;
      // scan downward so the lowest-numbered way wins
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (slot_valid[base + w] && slot_key[base + w] == key) hit = w;
         if (!slot_valid[base + w]) spare = w;
      end
      if (kind == mhtir_pkg::KIND_INSERT) begin
         if (hit >= 0) begin
            slot_value[base + hit] = value;
            res.status = mhtir_pkg::STATUS_UPDATED;
         end else if (spare >= 0) begin
            slot_valid[base + spare] = 1'b1;
            slot_key[base + spare]   = key;
            slot_value[base + spare] = value;
            slot_count++;
            res.status = mhtir_pkg::STATUS_INSERTED;
         end else begin
            res.status = mhtir_pkg::STATUS_FULL;
         end
      end else begin
         if (hit >= 0) begin
            slot_valid[base + hit] = 1'b0;
            if (slot_count > 0) slot_count--;
            res.status = mhtir_pkg::STATUS_REMOVED;
         end else begin
            res.status = mhtir_pkg::STATUS_NOTFOUND;
         end
      end
      res.table_empty = (slot_count == 0);
      return res;
   endfunction

   // Random occupied slot, or -1 when the table is empty
   function automatic int pick_valid_slot();
      int start;
      int s;
      start = $urandom_range(0, NUM_SLOTS - 1);
      for (int i = 0; i < NUM_SLOTS; i++) begin
         s = (start + i) % NUM_SLOTS;
         if (slot_valid[s]) return s;
      end
      return -1;
   endfunction

   // Mostly a few hot buckets, so buckets fill up and overflow
   function automatic int pick_bucket();
      if ($urandom_range(0, 9) < 6) return $urandom_range(0, 3);
      return $urandom_range(0, NUM_BUCKETS - 1);
   endfunction

   // Key in the given bucket: from a small set (repeats) or with random upper bits
   function automatic logic [KEY_W-1:0] key_for_bucket(input int bucket, input bit near);
      logic [KEY_W-1:0] k;
      if (near) begin
         k = KEY_W'(bucket + NUM_BUCKETS * $urandom_range(0, 7));
      end else begin
         k = KEY_W'($urandom());
         k = k - KEY_W'(k % NUM_BUCKETS) + KEY_W'(bucket);
      end
      return k;
   endfunction

   // Drive one request and hold it until the unit takes it
   task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
                               input logic [VALUE_W-1:0] value);
      @(negedge clock);
      req_chan.valid = 1'b1;
      req_chan.kind  = kind;
      req_chan.key   = key;
      req_chan.value = value;
      do @(posedge clock); while (!req_chan.ready);
      pending_results.push_back(apply_table_op(kind, key, value));
      requests_sent++;
   endtask

   // Sender gap with junk on the payload
   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         req_chan.kind  = 1'($urandom());
         req_chan.key   = KEY_W'($urandom());
         req_chan.value = $urandom();
      end
   endtask

   // Stop offering and wait until every predicted response has come back
   task automatic wait_all_responses();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
   endtask

   // Field extremes and each insert/remove outcome, the full cases on one bucket
   task automatic test_directed_cases();
      send_request(mhtir_pkg::KIND_INSERT, 31'd0, 32'h0000_0000);          // new key
      send_request(mhtir_pkg::KIND_INSERT, 31'd0, 32'hFFFF_FFFF);          // update
      send_request(mhtir_pkg::KIND_REMOVE, 31'd0, 32'h0000_0000);          // empty again
      send_request(mhtir_pkg::KIND_REMOVE, 31'd0, 32'hFFFF_FFFF);          // absent key
      send_request(mhtir_pkg::KIND_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);  // top key
      send_request(mhtir_pkg::KIND_INSERT, 31'd15, 32'h1234_5678);
      send_request(mhtir_pkg::KIND_INSERT, 31'd31, 32'hA5A5_A5A5);
      send_request(mhtir_pkg::KIND_INSERT, 31'd47, 32'h5A5A_5A5A);         // bucket full
      send_request(mhtir_pkg::KIND_INSERT, 31'd63, 32'hDEAD_BEEF);         // refused
      send_request(mhtir_pkg::KIND_INSERT, 31'd31, 32'h0000_0000);         // update, full
      send_request(mhtir_pkg::KIND_REMOVE, 31'd63, 32'h0000_0000);         // absent, full
      send_request(mhtir_pkg::KIND_REMOVE, 31'd31, 32'h0000_0000);         // frees way 2
      send_request(mhtir_pkg::KIND_INSERT, 31'd79, 32'hCAFE_F00D);         // lowest free
      send_request(mhtir_pkg::KIND_REMOVE, 31'h2AAA_AAAA, 32'h0000_0000);
      send_request(mhtir_pkg::KIND_INSERT, 31'h2AAA_AAAA, 32'h5555_5555);
      send_request(mhtir_pkg::KIND_INSERT, 31'h5555_5555, 32'hAAAA_AAAA);
      wait_all_responses();
   endtask

   // Remove every live entry back to back until the table is empty
   task automatic test_drain_table();
      int s;
      s = pick_valid_slot();
      while (s >= 0) begin
         send_request(mhtir_pkg::KIND_REMOVE, slot_key[s], $urandom());
         s = pick_valid_slot();
      end
      wait_all_responses();
   endtask

   // Mixed well-formed traffic in bursts with random gaps
   task automatic test_random_traffic(input int count);
      int sent;
      int burst;
      int r;
      int s;
      logic kind;
      logic [KEY_W-1:0] key;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            r = $urandom_range(0, 99);
            s = pick_valid_slot();
            if (r < 30) begin
               kind = mhtir_pkg::KIND_INSERT;
               key  = key_for_bucket(pick_bucket(), $urandom_range(0, 1));
            end else if (r < 45) begin
               // update of a live key
               kind = mhtir_pkg::KIND_INSERT;
               key  = (s >= 0) ? slot_key[s] : key_for_bucket(pick_bucket(), 1'b0);
            end else if (r < 75) begin
               // remove of a live key
               kind = mhtir_pkg::KIND_REMOVE;
               key  = (s >= 0) ? slot_key[s] : key_for_bucket(pick_bucket(), 1'b1);
            end else if (r < 85) begin
               kind = mhtir_pkg::KIND_REMOVE;
               key  = key_for_bucket(pick_bucket(), $urandom_range(0, 1));
            end else begin
               kind = mhtir_pkg::KIND_INSERT;
               key  = key_for_bucket(pick_bucket(), 1'b1);
            end
            send_request(kind, key, $urandom());
         end
         sent += burst;
         r = $urandom_range(0, 9);
         if (r >= 2 && r <= 7) idle_sender($urandom_range(1, 6));
         else if (r == 8) idle_sender($urandom_range(10, 30));
         else if (r == 9) wait_all_responses();
      end
      wait_all_responses();
   endtask

   // Receiver holds off for a long stretch while requests keep coming
   task automatic test_output_backpressure();
      hold_rsp = 1'b1;
      repeat (12) begin
         send_request(1'($urandom()), key_for_bucket(pick_bucket(), 1'b1), $urandom());
      end
      wait_all_responses();
      wait (!hold_rsp);
   endtask

   // Sender stops until everything is answered, then resumes
   task automatic test_pause_until_drained();
      repeat (3) begin
         repeat ($urandom_range(4, 10)) begin
            send_request(1'($urandom()), key_for_bucket(pick_bucket(), 1'b1), $urandom());
         end
         wait_all_responses();
      end
   endtask

   // Receiver ready pattern, plus the long hold-off on request
   initial begin : rsp_stall_pattern
      int mode;
      int mode_left;
      int phase;
      int held;
      mode      = RSP_ALWAYS_READY;
      mode_left = 0;
      phase     = 0;
      held      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_chan.ready = 1'b0;
            held++;
            if (held >= HOLD_CYCLES) begin
               hold_rsp = 1'b0;
               held     = 0;
            end
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(RSP_ALWAYS_READY, RSP_SPARSE);
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            phase++;
            case (mode)
               RSP_ALWAYS_READY: rsp_chan.ready = 1'b1;
               RSP_RANDOM_HALF:  rsp_chan.ready = 1'($urandom());
               RSP_EVERY_THIRD:  rsp_chan.ready = (phase % 3 != 0);
               default:          rsp_chan.ready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Response checker
   always @(posedge clock) begin : rsp_checker
      table_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response: status %0d table_empty %0b",
                   rsp_chan.status, rsp_chan.table_empty);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.status !== want.status) begin
               $error("status: expected %0d actual %0d", want.status, rsp_chan.status);
               mismatch_count++;
            end
            if (rsp_chan.table_empty !== want.table_empty) begin
               $error("table_empty: expected %0b actual %0b",
                      want.table_empty, rsp_chan.table_empty);
               mismatch_count++;
            end
            if (want.status <= mhtir_pkg::STATUS_FULL) status_seen[want.status]++;
            if (want.table_empty) empty_seen++;
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("timeout after %0d quiet cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Test sequence
   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.kind  = mhtir_pkg::KIND_INSERT;
      req_chan.key   = '0;
      req_chan.value = '0;
      hold_rsp       = 1'b0;
      mismatch_count = 0;
      requests_sent  = 0;
      empty_seen     = 0;
      slot_count     = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (slot_valid[i]) begin
         slot_valid[i] = 1'b0;
         slot_key[i]   = '0;
         slot_value[i] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_drain_table();
      test_random_traffic(320);
      test_drain_table();
      test_output_backpressure();
      test_pause_until_drained();
      test_random_traffic(320);
      test_drain_table();

      wait_all_responses();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d requests through full, partly filled and empty buckets", requests_sent);
      $display("Outcomes: %0d new, %0d updated, %0d removed, %0d absent, %0d full, %0d empty",
               status_seen[mhtir_pkg::STATUS_INSERTED], status_seen[mhtir_pkg::STATUS_UPDATED],
               status_seen[mhtir_pkg::STATUS_REMOVED], status_seen[mhtir_pkg::STATUS_NOTFOUND],
               status_seen[mhtir_pkg::STATUS_FULL], empty_seen);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
